// ----- design/sscr_pkg.sv -----
// shared types and constants for the spectrum screen cell renderer
`default_nettype none

package sscr_pkg;

   // screen area layout
   localparam int ScreenAw = 13;
   localparam int ScreenBytes = 6912;
   localparam logic [ScreenAw-1:0] ScreenLimit = 13'd6912;
   localparam logic [ScreenAw-1:0] BitmapBase = 13'd6144;
   localparam logic [ScreenAw-1:0] LastAddr = 13'd6911;

   // reset contents and row limit
   localparam logic [7:0] AttrReset = 8'h38;
   localparam logic [7:0] LastRow = 8'd191;

   // channel intensities
   localparam logic [7:0] LevelNormal = 8'hd7;
   localparam logic [7:0] LevelBright = 8'hff;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_RENDER = 1'b1
   } op_type;

   typedef struct packed {
      op_type      operation;
      logic [12:0] screen_offset;
      logic [7:0]  write_data;
      logic [7:0]  pixel_row;
      logic [4:0]  char_column;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [2:0] pixel_in_cell;
      logic       last;
   } rsp_type;

   // screen ram write port
   typedef struct packed {
      logic                en;
      logic [ScreenAw-1:0] addr;
      logic [7:0]          data;
   } ram_write_type;

endpackage

`default_nettype wire

// ----- design/sscr_screen_ram.sv -----
// screen ram: one write port, one read port with registered read data
`default_nettype none

module sscr_screen_ram (
   input  wire logic                          clock,
   input  wire sscr_pkg::ram_write_type       wr,
   input  wire logic [sscr_pkg::ScreenAw-1:0] rd_addr,
   output logic [7:0]                         rd_data
);

   logic [7:0] mem [sscr_pkg::ScreenBytes];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/spectrum_screen_cell_render.sv -----
// spectrum screen cell renderer: sequencer, shared address adder and pixel output
// a write transfer gives no result
// a render transfer passes the bitmap read, attribute read and load states before its
// first pixel, then gives one pixel per cycle while the output is not stalled; the one
// screen ram read port is used twice per cell (bitmap byte, then attribute byte)
// after reset a clearing pass over all 6912 bytes fills the bitmap with 0 and the
// attributes with 0x38; no transfer is taken during the pass
`default_nettype none

module spectrum_screen_cell_render (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sscr_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sscr_pkg::rsp_type      rsp_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_BMP,
      ST_RD_ATTR,
      ST_LOAD,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [sscr_pkg::ScreenAw-1:0] clr_ff, clr_in;
   logic [7:0] row_ff, row_in;
   logic [4:0] col_ff, col_in;
   logic [7:0] bits_ff, bits_in;
   logic [6:0] attr_ff, attr_in;
   logic [2:0] pix_ff, pix_in;

   sscr_pkg::ram_write_type ram_wr;
   logic [sscr_pkg::ScreenAw-1:0] rd_addr;
   logic [sscr_pkg::ScreenAw-1:0] rd_base;
   logic [sscr_pkg::ScreenAw-1:0] rd_offset;
   logic [7:0] rd_data;
   logic rd_attr_sel;

   logic [2:0] colour;
   logic [7:0] level;

   // shared address adder: bitmap or attribute address of the cell
   always_comb begin
      rd_base = rd_attr_sel ? sscr_pkg::BitmapBase : '0;
      rd_offset = rd_attr_sel ? {3'b000, row_ff[7:3], col_ff}
                              : {row_ff[7:6], row_ff[2:0], row_ff[5:3], col_ff};
      rd_addr = rd_base + rd_offset;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      row_in = row_ff;
      col_in = col_ff;
      bits_in = bits_ff;
      attr_in = attr_ff;
      pix_in = pix_ff;
      ram_wr = '0;
      rd_attr_sel = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr.en = 1'b1;
            ram_wr.addr = clr_ff;
            ram_wr.data = (clr_ff >= sscr_pkg::BitmapBase) ? sscr_pkg::AttrReset : 8'h00;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == sscr_pkg::LastAddr) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.operation == sscr_pkg::OP_WRITE) begin
                  // offsets past the screen area are dropped
                  ram_wr.en = (req_data.screen_offset < sscr_pkg::ScreenLimit);
                  ram_wr.addr = req_data.screen_offset;
                  ram_wr.data = req_data.write_data;
               end else begin
                  row_in = (req_data.pixel_row > sscr_pkg::LastRow) ? sscr_pkg::LastRow
                                                                    : req_data.pixel_row;
                  col_in = req_data.char_column;
                  state_in = ST_RD_BMP;
               end
            end
         end
         ST_RD_BMP: begin
            state_in = ST_RD_ATTR;
         end
         ST_RD_ATTR: begin
            rd_attr_sel = 1'b1;
            bits_in = rd_data;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rd_attr_sel = 1'b1;
            attr_in = rd_data[6:0];
            pix_in = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               bits_in = {bits_ff[6:0], 1'b0};
               pix_in = pix_ff + 1'b1;
               if (pix_ff == 3'd7) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         pix_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         pix_ff <= pix_in;
      end
      row_ff <= row_in;
      col_ff <= col_in;
      bits_ff <= bits_in;
      attr_ff <= attr_in;
   end

   sscr_screen_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // pixel colour: ink for a set bit, paper for a clear one
   always_comb begin
      colour = bits_ff[7] ? attr_ff[2:0] : attr_ff[5:3];
      level = attr_ff[6] ? sscr_pkg::LevelBright : sscr_pkg::LevelNormal;
      rsp_data.red = colour[1] ? level : 8'h00;
      rsp_data.green = colour[2] ? level : 8'h00;
      rsp_data.blue = colour[0] ? level : 8'h00;
      rsp_data.pixel_in_cell = pix_ff;
      rsp_data.last = (pix_ff == 3'd7);
   end

   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_stall = (state_ff != ST_IDLE);

   // a render transfer reaches its first pixel after the bitmap read, attribute read and load states
   a_render_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.operation == sscr_pkg::OP_RENDER)
      |-> ##4 (rsp_valid && rsp_data.pixel_in_cell == 3'd0))
      else $error("render did not reach first pixel in time");

   // a cell always starts at the leftmost pixel
   a_cell_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_data.pixel_in_cell == 3'd0))
      else $error("cell started at wrong pixel");

   // the last pixel transfer ends the cell and frees the input
   a_cell_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last) |=> (!rsp_valid && !req_stall))
      else $error("cell did not end after last pixel");

   // no input transfer while pixels are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken during cell output");

endmodule

`default_nettype wire
